// ----- src/pde_pkg.sv -----
`default_nettype none

package pde_pkg;

   // Field and word widths
   localparam int WORD_W    = 32;
   localparam int PROD_W    = 2 * WORD_W;
   localparam int DEG_W     = 3;
   localparam int ORDER_W   = 3;
   localparam int COUNT_W   = 4;
   localparam int FACT_W    = 7;
   localparam int REQ_W     = 40;
   localparam int RSP_W     = 40;

   // Defaults for the top-level parameters
   localparam int MAX_DEGREE_DEF = 5;
   localparam int MAX_VALUES_DEF = 8;
   localparam int FRAC_BITS_DEF  = 16;

   // Largest order that ever gets scaled (degree five at most)
   localparam int MAX_FACT_ARG = 5;

   // Register map
   localparam int COEF_REGS = 6;
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_LAST = CSR_IDX_W'(COEF_REGS - 1);
   localparam logic [CSR_IDX_W-1:0] CSR_DEGREE    = CSR_IDX_W'(COEF_REGS);
   localparam logic [DEG_W-1:0]     DEGREE_RESET  = DEG_W'(1);

   typedef logic signed [WORD_W-1:0] word_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef word_type [COEF_REGS-1:0] coef_bank_type;

   // Configuration as seen by the datapath
   typedef struct packed {
      coef_bank_type          coef;
      logic [DEG_W-1:0]       degree;
   } cfg_type;

   typedef struct packed {
      word_type value;
      logic     hit;
   } clip_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_MUL,
      ST_ADD,
      ST_SCALE,
      ST_CLIP,
      ST_EMIT
   } state_type;

   // Saturate a wide signed value into one word
   function automatic clip_type clip_word(input prod_type v);
      clip_type r;
      logic     all_one;
      logic     any_one;
      all_one = &v[PROD_W-1:WORD_W-1];
      any_one = |v[PROD_W-1:WORD_W-1];
      r.hit   = any_one && !all_one;
      if (r.hit) begin
         r.value = v[PROD_W-1] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
      end else begin
         r.value = v[WORD_W-1:0];
      end
      return r;
   endfunction

   // j! for the orders that are scaled
   function automatic logic [FACT_W-1:0] factorial(input logic [ORDER_W-1:0] j);
      logic [FACT_W-1:0] f;
      f = FACT_W'(1);
      for (int i = 2; i <= MAX_FACT_ARG; i++) begin
         if (ORDER_W'(i) <= j) begin
            f = FACT_W'(f * i);
         end
      end
      return f;
   endfunction

endpackage

`default_nettype wire

// ----- src/pde_mul.sv -----
`default_nettype none

// Shared signed multiplier, product registered
module pde_mul (
   input  wire logic              clock,
   input  wire logic              enable,
   input  wire pde_pkg::word_type op_a,
   input  wire pde_pkg::word_type op_b,
   output pde_pkg::prod_type      prod_ff
);

   pde_pkg::prod_type prod_in;

   assign prod_in = pde_pkg::PROD_W'(op_a) * pde_pkg::PROD_W'(op_b);

   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff <= prod_in;
      end
   end

endmodule

`default_nettype wire

// ----- src/pde_csr.sv -----
`default_nettype none

// Coefficient and degree registers
module pde_csr #(
   parameter int FRAC_BITS = pde_pkg::FRAC_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [pde_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [pde_pkg::WORD_W-1:0]      csr_wdata,
   output pde_pkg::cfg_type                     cfg
);

   localparam pde_pkg::word_type ONE_FIX = pde_pkg::WORD_W'(1) << FRAC_BITS;

   // reset polynomial is 1 - x
   localparam pde_pkg::coef_bank_type COEF_RESET =
      {{(pde_pkg::COEF_REGS - 2){pde_pkg::word_type'(0)}}, -ONE_FIX, ONE_FIX};

   pde_pkg::coef_bank_type        coef_ff, coef_in;
   logic [pde_pkg::DEG_W-1:0]     degree_ff, degree_in;

   assign csr_ready = 1'b1;

   // Register write decode; indices beyond the map are dropped
   always_comb begin
      coef_in   = coef_ff;
      degree_in = degree_ff;
      if (csr_valid) begin
         if (csr_index <= pde_pkg::CSR_COEF_LAST) begin
            coef_in[csr_index] = csr_wdata;
         end else if (csr_index == pde_pkg::CSR_DEGREE) begin
            degree_in = csr_wdata[pde_pkg::DEG_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff    <= COEF_RESET;
         degree_ff  <= pde_pkg::DEGREE_RESET;
      end else begin
         coef_ff    <= coef_in;
         degree_ff  <= degree_in;
      end
   end

   assign cfg.coef   = coef_ff;
   assign cfg.degree = degree_ff;

endmodule

`default_nettype wire

// ----- src/poly_eval_with_derivatives.sv -----
`default_nettype none

// Polynomial value and derivatives at a point x, by repeated Horner
// synthetic division over a working copy of the coefficients. A request
// carries x and the number of results wanted; the block returns one
// response per order, 0 (the value) upwards, each derivative scaled by
// j!, with rsp_tlast on the final one and rsp_tuser set when any step
// feeding that response saturated. Orders above the degree return zero.
// One request is processed at a time and req_tready is low until its
// last response has been taken. All arithmetic runs through a single
// registered 32x32 multiplier followed by an add-and-clip step: for an
// order j at or below degree d a response takes one multiply and one
// update per division step (d - j steps), then a multiply by j! and a
// clip; an order above the degree skips the arithmetic. The request is
// accepted first, and a response may be held off by rsp_tready.
module poly_eval_with_derivatives #(
   parameter int MAX_DEGREE = pde_pkg::MAX_DEGREE_DEF,
   parameter int MAX_VALUES = pde_pkg::MAX_VALUES_DEF,
   parameter int FRAC_BITS  = pde_pkg::FRAC_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request: point[31:0], values_wanted[35:32], zero pad [39:36]
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [pde_pkg::REQ_W-1:0]       req_tdata,
   // response: order[2:0], result_value[34:3], zero pad [39:35]
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [pde_pkg::RSP_W-1:0]            rsp_tdata,
   // response: saturated[0]
   output logic                                 rsp_tuser,
   output logic                                 rsp_tlast,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [pde_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [pde_pkg::WORD_W-1:0]      csr_wdata
);

   localparam int NUM_A = MAX_DEGREE + 1;
   localparam int AW    = $clog2(MAX_DEGREE + 1);
   localparam int MW    = $clog2(MAX_DEGREE + 2);
   localparam int NW    = $clog2(MAX_VALUES + 1);
   localparam int CW    = pde_pkg::COUNT_W;
   localparam int OW    = pde_pkg::ORDER_W;
   localparam int WW    = pde_pkg::WORD_W;

   pde_pkg::cfg_type    cfg;
   pde_pkg::state_type  state_ff, state_in;

   pde_pkg::word_type   x_ff, x_in;
   logic [NW-1:0]       n_ff, n_in;
   logic [MW-1:0]       m_ff, m_in;
   logic [OW-1:0]       j_ff, j_in;
   logic [AW-1:0]       k_ff, k_in;
   pde_pkg::word_type   c_ff, c_in;
   logic                ctag_ff, ctag_in;
   pde_pkg::word_type   a_ff [NUM_A];
   pde_pkg::word_type   a_in [NUM_A];
   logic [NUM_A-1:0]    tag_ff, tag_in;
   pde_pkg::word_type   val_ff, val_in;
   logic                sat_ff, sat_in;

   logic                mul_en;
   pde_pkg::word_type   mul_a, mul_b;
   pde_pkg::prod_type   prod;

   pde_pkg::word_type   req_point;
   logic [CW-1:0]       req_count;
   logic [pde_pkg::DEG_W-1:0] deg_clamp;
   logic [AW-1:0]       rd_idx;
   pde_pkg::word_type   a_rd;
   logic                tag_rd;
   pde_pkg::prod_type   sum;
   pde_pkg::clip_type   add_clip, scale_clip;
   logic                has_pass, more_steps, last_step, is_last;

   pde_csr #(
      .FRAC_BITS (FRAC_BITS)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pde_mul u_mul (
      .clock   (clock),
      .enable  (mul_en),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (prod)
   );

   assign req_point = req_tdata[WW-1:0];
   assign req_count = req_tdata[WW+CW-1:WW];
   assign deg_clamp = (cfg.degree > pde_pkg::DEG_W'(MAX_DEGREE)) ?
                      pde_pkg::DEG_W'(MAX_DEGREE) : cfg.degree;

   // Loop conditions
   assign has_pass   = CW'(j_ff) < CW'(m_ff);
   assign more_steps = (CW'(j_ff) + CW'(1)) < CW'(m_ff);
   assign last_step  = CW'(k_ff) == CW'(j_ff);
   assign is_last    = (CW'(j_ff) + CW'(1)) == CW'(n_ff);

   // Single read port on the working coefficients
   assign rd_idx = (state_ff == pde_pkg::ST_START) ? AW'(m_ff - MW'(1)) : k_ff;
   assign a_rd   = a_ff[rd_idx];
   assign tag_rd = tag_ff[rd_idx];

   // a[k] + floor(x * a[k+1] / 2^F), then clip
   assign sum        = pde_pkg::PROD_W'(a_rd) + (prod >>> FRAC_BITS);
   assign add_clip   = pde_pkg::clip_word(sum);
   assign scale_clip = pde_pkg::clip_word(prod);

   // Sequencer: next state, datapath updates, multiplier operands
   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      n_in     = n_ff;
      m_in     = m_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      c_in     = c_ff;
      ctag_in  = ctag_ff;
      a_in     = a_ff;
      tag_in   = tag_ff;
      val_in   = val_ff;
      sat_in   = sat_ff;
      mul_en   = 1'b0;
      mul_a    = x_ff;
      mul_b    = c_ff;

      unique case (state_ff)
         pde_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               x_in   = req_point;
               n_in   = (req_count > CW'(MAX_VALUES)) ? NW'(MAX_VALUES) : NW'(req_count);
               m_in   = MW'(deg_clamp) + MW'(1);
               j_in   = '0;
               tag_in = '0;
               for (int i = 0; i < NUM_A; i++) begin
                  a_in[i] = cfg.coef[i];
               end
               state_in = (req_count == '0) ? pde_pkg::ST_IDLE : pde_pkg::ST_START;
            end
         end
         pde_pkg::ST_START: begin
            if (has_pass) begin
               // carry starts at the top coefficient, never updated
               c_in    = a_rd;
               ctag_in = tag_rd;
               k_in    = AW'(m_ff - MW'(2));
               state_in = more_steps ? pde_pkg::ST_MUL : pde_pkg::ST_SCALE;
            end else begin
               val_in   = '0;
               sat_in   = 1'b0;
               state_in = pde_pkg::ST_EMIT;
            end
         end
         pde_pkg::ST_MUL: begin
            mul_en   = 1'b1;
            state_in = pde_pkg::ST_ADD;
         end
         pde_pkg::ST_ADD: begin
            a_in[k_ff]   = add_clip.value;
            tag_in[k_ff] = tag_rd | ctag_ff | add_clip.hit;
            c_in         = add_clip.value;
            ctag_in      = tag_rd | ctag_ff | add_clip.hit;
            if (last_step) begin
               state_in = pde_pkg::ST_SCALE;
            end else begin
               k_in     = k_ff - AW'(1);
               state_in = pde_pkg::ST_MUL;
            end
         end
         pde_pkg::ST_SCALE: begin
            mul_en   = 1'b1;
            mul_a    = c_ff;
            mul_b    = WW'(pde_pkg::factorial(j_ff));
            state_in = pde_pkg::ST_CLIP;
         end
         pde_pkg::ST_CLIP: begin
            val_in   = scale_clip.value;
            sat_in   = ctag_ff | scale_clip.hit;
            state_in = pde_pkg::ST_EMIT;
         end
         pde_pkg::ST_EMIT: begin
            if (rsp_tready) begin
               if (is_last) begin
                  state_in = pde_pkg::ST_IDLE;
               end else begin
                  j_in     = j_ff + OW'(1);
                  state_in = pde_pkg::ST_START;
               end
            end
         end
         default: begin
            state_in = pde_pkg::ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pde_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      n_ff    <= n_in;
      m_ff    <= m_in;
      j_ff    <= j_in;
      k_ff    <= k_in;
      c_ff    <= c_in;
      ctag_ff <= ctag_in;
      a_ff    <= a_in;
      tag_ff  <= tag_in;
      val_ff  <= val_in;
      sat_ff  <= sat_in;
   end

   assign req_tready = (state_ff == pde_pkg::ST_IDLE);
   assign rsp_tvalid = (state_ff == pde_pkg::ST_EMIT);
   assign rsp_tdata  = {(pde_pkg::RSP_W - OW - WW)'(0), val_ff, j_ff};
   assign rsp_tuser  = sat_ff;
   assign rsp_tlast  = is_last;

endmodule

`default_nettype wire

// ----- src/pde_checker.sv -----
`default_nettype none

// Port-level checks on the evaluator
module pde_checker (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   input  wire logic                        req_tready,
   input  wire logic                        rsp_tvalid,
   input  wire logic                        rsp_tready,
   input  wire logic [pde_pkg::RSP_W-1:0]   rsp_tdata,
   input  wire logic                        rsp_tuser,
   input  wire logic                        rsp_tlast
);

   // held response keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("response changed while held");

   // one request in flight: no new request while a response waits
   assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request taken while a response is pending");

   // a response never appears in the cycle after a request is taken
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !rsp_tvalid)
      else $error("response too early after request");

   // mid-run response is followed by more work, not a new request
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> !req_tready && !rsp_tvalid)
      else $error("run ended without a last response");

endmodule

bind poly_eval_with_derivatives pde_checker u_checker (.*);

`default_nettype wire
